// File: design/pad_button_remapper_top_defines.svh
// assertion macros for the pad button remapper
// used by pad_button_remapper_top only
`ifndef PAD_BUTTON_REMAPPER_TOP_DEFINES_SVH
`define PAD_BUTTON_REMAPPER_TOP_DEFINES_SVH

// same-cycle implication, reset gated
`define PBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pad button remapper check failed");

// next-cycle implication, reset gated
`define PBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pad button remapper check failed");

`endif

// File: design/pbr_pkg.sv
// shared types, button codes and helpers for the pad button remapper
// no dependencies
package pbr_pkg;

	localparam int PORT_COUNT = 4;
	localparam int PORT_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	typedef logic [PORT_W-1:0] port_idx_t;

	localparam logic [15:0] BTN_Z = 16'h0010;
	localparam logic [15:0] BTN_R = 16'h0020;
	localparam logic [15:0] BTN_L = 16'h0040;
	localparam logic [15:0] BTN_X = 16'h0400;
	localparam logic [15:0] BTN_Y = 16'h0800;
	localparam logic [15:0] FACE_PAIR    = BTN_X | BTN_Y;
	localparam logic [15:0] SHOULDER_SET = BTN_L | BTN_R | BTN_Z;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_POLLS = 1'd1;

	localparam logic [7:0] DEADZONE_RST   = 8'd0;
	localparam logic [7:0] HOLD_POLLS_RST = 8'd60;

	typedef struct packed {
		logic [7:0] deadzone;
		logic [7:0] hold_polls;
	} cfg_t;

	typedef struct packed {
		logic        in_setup;
		logic        unplugged;
		logic [7:0]  trigger_r;
		logic [7:0]  trigger_l;
		logic [15:0] buttons;
		logic [1:0]  port;
	} item_t;

	typedef struct packed {
		logic        remap_active;
		logic        rumble_pulse;
		logic [7:0]  trigger_r;
		logic [7:0]  trigger_l;
		logic [15:0] buttons;
	} result_t;

	typedef struct packed {
		logic [15:0] mask;
		logic [7:0]  count;
	} port_state_t;

	function automatic logic single_bit(input logic [15:0] v);
		return (v != 16'd0) && ((v & (v - 16'd1)) == 16'd0);
	endfunction

endpackage

// File: design/pbr_cfg.sv
// configuration registers: trigger deadzone and hold poll count
// depends on pbr_pkg
module pbr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	output pbr_pkg::cfg_t                  cfg
);

	pbr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone   <= pbr_pkg::DEADZONE_RST;
			cfg_q.hold_polls <= pbr_pkg::HOLD_POLLS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				pbr_pkg::CFG_DEADZONE:   cfg_q.deadzone   <= cfg_data;
				pbr_pkg::CFG_HOLD_POLLS: cfg_q.hold_polls <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/pbr_state.sv
// per-port remap mask and hold counter storage, one read and one write port
// depends on pbr_pkg
module pbr_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbr_pkg::port_idx_t    rd_port,
	output pbr_pkg::port_state_t  rd_state,
	input  logic                  wr_en,
	input  pbr_pkg::port_idx_t    wr_port,
	input  pbr_pkg::port_state_t  wr_state
);

	pbr_pkg::port_state_t state_q [pbr_pkg::PORT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pbr_pkg::PORT_COUNT; i++) begin
				state_q[i] <= '0;
			end
		end else if (wr_en) begin
			state_q[wr_port] <= wr_state;
		end
	end

	assign rd_state = state_q[rd_port];

endmodule

// File: design/pbr_remap.sv
// one poll through the remap: setup hold detection, button swap, trigger handling
// depends on pbr_pkg
module pbr_remap (
	input  pbr_pkg::item_t        item,
	input  pbr_pkg::cfg_t         cfg,
	input  pbr_pkg::port_state_t  cur,
	output logic                  in_range,
	output pbr_pkg::port_state_t  nxt,
	output pbr_pkg::result_t      res
);

	logic [15:0] face;
	logic [15:0] shoulder;
	logic [7:0]  cnt_inc;
	logic [15:0] mask;
	logic [15:0] fm;
	logic [15:0] sm;
	logic [15:0] seen;
	logic [7:0]  tl;
	logic [7:0]  tr;
	logic        rumble;

	assign face     = item.buttons & pbr_pkg::FACE_PAIR;
	assign shoulder = item.buttons & pbr_pkg::SHOULDER_SET;
	assign cnt_inc  = cur.count + 8'd1;
	assign in_range = (32'(item.port) < pbr_pkg::PORT_COUNT);

	always_comb begin
		nxt    = cur;
		rumble = 1'b0;
		if (item.unplugged) begin
			nxt = '0;
		end else if (item.in_setup && (cur.mask == 16'd0)) begin
			if (!pbr_pkg::single_bit(face) || !pbr_pkg::single_bit(shoulder)) begin
				nxt.count = 8'd0;
			end else if (cnt_inc >= cfg.hold_polls) begin
				nxt.count = 8'd0;
				nxt.mask  = face | shoulder;
				rumble    = 1'b1;
			end else begin
				nxt.count = cnt_inc;
			end
		end
	end

	assign mask = nxt.mask;
	assign fm   = mask & pbr_pkg::FACE_PAIR;
	assign sm   = mask & pbr_pkg::SHOULDER_SET;

	// l wins over r for analog handling
	always_comb begin
		seen = item.buttons;
		tl   = item.trigger_l;
		tr   = item.trigger_r;
		if ((sm & pbr_pkg::BTN_L) != 16'd0) begin
			if (item.trigger_l > cfg.deadzone) begin
				seen = seen | pbr_pkg::BTN_L;
			end
			tl = 8'd0;
		end else if ((sm & pbr_pkg::BTN_R) != 16'd0) begin
			if (item.trigger_r > cfg.deadzone) begin
				seen = seen | pbr_pkg::BTN_R;
			end
			tr = 8'd0;
		end
	end

	always_comb begin
		res.buttons      = item.buttons;
		res.trigger_l    = item.trigger_l;
		res.trigger_r    = item.trigger_r;
		res.rumble_pulse = 1'b0;
		res.remap_active = 1'b0;
		if (in_range && !item.unplugged) begin
			res.rumble_pulse = rumble;
			if (mask != 16'd0) begin
				res.buttons = (item.buttons & ~mask)
					| (((seen & fm) != 16'd0) ? sm : 16'd0)
					| (((seen & sm) != 16'd0) ? fm : 16'd0);
				res.trigger_l    = tl;
				res.trigger_r    = tr;
				res.remap_active = 1'b1;
			end
		end
	end

endmodule

// File: design/pad_button_remapper_top.sv
// pad button remapper top level: input register, remap logic, result register
// depends on pbr_pkg, pbr_cfg, pbr_state, pbr_remap and the defines header
//
// usage
//   slave channel s_*: one controller poll per item. s_tdata holds port, buttons,
//   left and right trigger levels; s_tuser holds the unplugged and in-setup flags.
//   master channel m_*: one result per poll, in order: buttons after the swap,
//   both trigger levels, and in m_tuser the rumble pulse and remap-active flags.
//   cfg_wen/cfg_index/cfg_data write the deadzone (index 0) and hold count
//   (index 1); write only while no poll is in flight.
//   a poll accepted into the input register passes the remap logic into the result
//   register, which drives m_*.
//   throughput: one item per cycle while the result register is free to advance;
//   a port's mask and hold counter are read and written back in the same cycle,
//   so polls to the same port may follow back to back.
//   reset clears all port masks and counters, the deadzone to 0 and the hold
//   count to 60; both channels come out empty.
//   when m_tready is low the result register holds its item, the input
//   register can still take one more item, then s_tready drops.
`include "pad_button_remapper_top_defines.svh"

module pad_button_remapper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // port[1:0], buttons_in[17:2], trigger_l_in[25:18],
	                               // trigger_r_in[33:26], zero[39:34]
	input  logic [1:0]  s_tuser,   // unplugged[0], in_setup[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // buttons_out[15:0], trigger_l_out[23:16],
	                               // trigger_r_out[31:24]
	output logic [1:0]  m_tuser,   // rumble_pulse[0], remap_active[1]
	input  logic                           cfg_wen,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data
);

	pbr_pkg::cfg_t         cfg;
	pbr_pkg::item_t        item_s1;
	logic                  valid_s1;
	pbr_pkg::result_t      res_s2;
	logic                  valid_s2;
	pbr_pkg::port_state_t  cur_state;
	pbr_pkg::port_state_t  nxt_state;
	pbr_pkg::result_t      res;
	pbr_pkg::port_idx_t    port_idx;
	logic                  in_range;
	logic                  out_free;
	logic                  adv_s1;
	logic                  in_accept;

	assign out_free  = !valid_s2 || m_tready;
	assign adv_s1    = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_accept = s_tvalid && s_tready;
	assign port_idx  = pbr_pkg::port_idx_t'(item_s1.port);

	pbr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pbr_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_port  (port_idx),
		.rd_state (cur_state),
		.wr_en    (adv_s1 && in_range),
		.wr_port  (port_idx),
		.wr_state (nxt_state)
	);

	pbr_remap u_remap (
		.item     (item_s1),
		.cfg      (cfg),
		.cur      (cur_state),
		.in_range (in_range),
		.nxt      (nxt_state),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.port      <= s_tdata[1:0];
			item_s1.buttons   <= s_tdata[17:2];
			item_s1.trigger_l <= s_tdata[25:18];
			item_s1.trigger_r <= s_tdata[33:26];
			item_s1.unplugged <= s_tuser[0];
			item_s1.in_setup  <= s_tuser[1];
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.trigger_r, res_s2.trigger_l, res_s2.buttons};
	assign m_tuser  = {res_s2.remap_active, res_s2.rumble_pulse};

	// a newly stored remap is always active on the same poll
	`PBR_ASSERT_NOW(a_rumble_active, clk, arst_n, m_tvalid && m_tuser[0], m_tuser[1])
	// an unplugged poll never reports a remap
	`PBR_ASSERT_NEXT(a_unplug_clear, clk, arst_n, adv_s1 && item_s1.unplugged, m_tuser == 2'b00)
	// every processed item lands in the result register
	`PBR_ASSERT_NEXT(a_adv_lands, clk, arst_n, adv_s1, m_tvalid)

endmodule

// File: bench/pad_button_remapper_top_tb.sv
`timescale 1ns / 100ps
// testbench for pad_button_remapper_top: directed and random controller polls,
// each result checked against a behavioral model of the per-port remap logic
// depends on pbr_pkg and the pad_button_remapper_top rtl

module pad_button_remapper_top_tb;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [39:0]                   s_tdata;   // port[1:0], buttons_in[17:2],
	                                          // trigger_l_in[25:18], trigger_r_in[33:26],
	                                          // zero[39:34]
	logic [1:0]                    s_tuser;   // unplugged[0], in_setup[1]
	logic                          m_tvalid;
	logic                          m_tready;
	logic [31:0]                   m_tdata;   // buttons_out[15:0], trigger_l_out[23:16],
	                                          // trigger_r_out[31:24]
	logic [1:0]                    m_tuser;   // rumble_pulse[0], remap_active[1]
	logic                          cfg_wen;
	logic [pbr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	// model of the block: per-port swap mask and hold counter, plus both registers
	logic [15:0]       port_mask [pbr_pkg::PORT_COUNT];
	logic [7:0]        port_hold [pbr_pkg::PORT_COUNT];
	logic [7:0]        dz_level;
	logic [7:0]        hold_need;
	pbr_pkg::result_t  pending_results [$];

	int  errors = 0;
	int  polls_sent = 0;
	int  results_seen = 0;
	int  rumbles_seen = 0;
	int  settings_used = 0;
	bit  tx_gaps = 1'b0;
	int  burst_left = 0;
	int  stall_pct = 0;
	int  rx_hold_left = 0;
	int  rx_run = 0;
	bit  rx_stalled = 1'b0;

	pad_button_remapper_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic pbr_pkg::result_t remap_poll(input pbr_pkg::item_t it);
		pbr_pkg::result_t r;
		logic [15:0]      btn, face, shoulder, m, fm, sm, seen;
		logic [7:0]       tl, tr, nxt;
		int               p;
		p = int'(it.port);
		btn = it.buttons;
		tl = it.trigger_l;
		tr = it.trigger_r;
		r.rumble_pulse = 1'b0;
		r.remap_active = 1'b0;
		if (p < pbr_pkg::PORT_COUNT) begin
			if (it.unplugged) begin
				port_mask[p] = 16'd0;
				port_hold[p] = 8'd0;
			end else begin
				if (it.in_setup && port_mask[p] == 16'd0) begin
					face = btn & pbr_pkg::FACE_PAIR;
					shoulder = btn & pbr_pkg::SHOULDER_SET;
					if ($countones(face) != 1 || $countones(shoulder) != 1) begin
						port_hold[p] = 8'd0;
					end else begin
						// count first, then compare, so a hold of 0 behaves as 1
						nxt = port_hold[p] + 8'd1;
						if (nxt >= hold_need) begin
							port_hold[p] = 8'd0;
							port_mask[p] = face | shoulder;
							r.rumble_pulse = 1'b1;
						end else begin
							port_hold[p] = nxt;
						end
					end
				end
				if (port_mask[p] != 16'd0) begin
					m = port_mask[p];
					fm = m & pbr_pkg::FACE_PAIR;
					sm = m & pbr_pkg::SHOULDER_SET;
					seen = btn;
					// a swapped shoulder trigger also fires on its analog level
					if ((sm & pbr_pkg::BTN_L) != 16'd0) begin
						if (tl > dz_level)
							seen = seen | pbr_pkg::BTN_L;
						tl = 8'd0;
					end else if ((sm & pbr_pkg::BTN_R) != 16'd0) begin
						if (tr > dz_level)
							seen = seen | pbr_pkg::BTN_R;
						tr = 8'd0;
					end
					btn = btn & ~m;
					if ((seen & fm) != 16'd0)
						btn = btn | sm;
					if ((seen & sm) != 16'd0)
						btn = btn | fm;
					r.remap_active = 1'b1;
				end
			end
		end
		r.buttons = btn;
		r.trigger_l = tl;
		r.trigger_r = tr;
		return r;
	endfunction

	function automatic pbr_pkg::item_t pad_poll(input logic [1:0] p, input logic [15:0] b,
			input logic [7:0] tl, input logic [7:0] tr, input logic unpl, input logic setup);
		pbr_pkg::item_t it;
		it.port = p;
		it.buttons = b;
		it.trigger_l = tl;
		it.trigger_r = tr;
		it.unplugged = unpl;
		it.in_setup = setup;
		return it;
	endfunction

	function automatic logic [7:0] level_near(input logic [7:0] dz);
		case ($urandom_range(0, 3))
			0: return dz;
			1: return (dz == 8'hff) ? dz : dz + 8'd1;
			2: return (dz == 8'h00) ? dz : dz - 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	// offer one item, holding it until accepted; valid stays high for a following item
	task automatic send_poll(input pbr_pkg::item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = tx_gaps ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tdata = {6'd0, it.trigger_r, it.trigger_l, it.buttons, it.port};
		s_tuser = {it.in_setup, it.unplugged};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(remap_poll(it));
		polls_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle_polls();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pbr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		if (idx == pbr_pkg::CFG_DEADZONE)
			dz_level = val;
		else if (idx == pbr_pkg::CFG_HOLD_POLLS)
			hold_need = val;
	endtask

	// receiver: runs of ready and stall, plus an optional long hold-off
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready = 1'b0;
			rx_hold_left--;
		end else if (stall_pct == 0) begin
			m_tready = 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_stalled = ($urandom_range(0, 99) < stall_pct);
				rx_run = $urandom_range(1, 9);
			end
			rx_run--;
			m_tready = !rx_stalled;
		end
	end

	always @(posedge clk) begin : check_results
		pbr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0])
				rumbles_seen++;
			if (pending_results.size() == 0) begin
				$error("result item with no poll outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.buttons) begin
					$error("buttons_out expected %h got %h", want.buttons, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[23:16] !== want.trigger_l) begin
					$error("trigger_l_out expected %h got %h", want.trigger_l, m_tdata[23:16]);
					errors++;
				end
				if (m_tdata[31:24] !== want.trigger_r) begin
					$error("trigger_r_out expected %h got %h", want.trigger_r, m_tdata[31:24]);
					errors++;
				end
				if (m_tuser[0] !== want.rumble_pulse) begin
					$error("rumble_pulse expected %b got %b", want.rumble_pulse, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.remap_active) begin
					$error("remap_active expected %b got %b", want.remap_active, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		settle_polls();
		tx_gaps = 1'b0;
		stall_pct = 0;
		write_reg(pbr_pkg::CFG_DEADZONE, 8'd100);
		write_reg(pbr_pkg::CFG_HOLD_POLLS, 8'd2);
		settings_used++;
		// field extremes outside setup and while unplugged
		send_poll(pad_poll(2'd0, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0));
		send_poll(pad_poll(2'd1, 16'hffff, 8'hff, 8'hff, 1'b1, 1'b1));
		// both X and Y held: not a valid pair
		send_poll(pad_poll(2'd2, 16'hffff, 8'hff, 8'h00, 1'b0, 1'b1));
		// X with L held for two polls stores the pair
		send_poll(pad_poll(2'd3, 16'h8000 | pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'h10, 8'hff,
			1'b0, 1'b1));
		send_poll(pad_poll(2'd3, pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'h80, 8'h20, 1'b0, 1'b1));
		// analog exactly at the deadzone, then just above it
		send_poll(pad_poll(2'd3, pbr_pkg::BTN_L, 8'd100, 8'd0, 1'b0, 1'b0));
		send_poll(pad_poll(2'd3, 16'h0000, 8'd101, 8'd7, 1'b0, 1'b0));
		send_poll(pad_poll(2'd3, pbr_pkg::BTN_X, 8'd0, 8'd0, 1'b0, 1'b0));
		// a stored remap ignores a new pair in setup
		send_poll(pad_poll(2'd3, pbr_pkg::BTN_Y | pbr_pkg::BTN_Z, 8'hff, 8'hff, 1'b0, 1'b1));
		// Y with R, right analog drives the swap
		send_poll(pad_poll(2'd0, pbr_pkg::BTN_Y | pbr_pkg::BTN_R, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd0, pbr_pkg::BTN_Y | pbr_pkg::BTN_R, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd0, 16'h0000, 8'd5, 8'hff, 1'b0, 1'b0));
		// unplug clears the remap
		send_poll(pad_poll(2'd0, pbr_pkg::BTN_Y | pbr_pkg::BTN_R, 8'd9, 8'd9, 1'b1, 1'b0));
		send_poll(pad_poll(2'd0, pbr_pkg::BTN_Y, 8'd0, 8'd0, 1'b0, 1'b0));
		// Z has no analog, both triggers pass through
		send_poll(pad_poll(2'd1, pbr_pkg::BTN_X | pbr_pkg::BTN_Z, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd1, pbr_pkg::BTN_X | pbr_pkg::BTN_Z, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd1, pbr_pkg::BTN_Z, 8'hff, 8'hff, 1'b0, 1'b0));
		// broken hold restarts; outside setup the count is kept
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_X, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'd0, 8'd0, 1'b0, 1'b1));
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'd0, 8'd0, 1'b0, 1'b0));
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_X | pbr_pkg::BTN_L, 8'd0, 8'd0, 1'b0, 1'b1));
		// hold of zero stores on the first qualifying poll
		settle_polls();
		write_reg(pbr_pkg::CFG_HOLD_POLLS, 8'd0);
		send_poll(pad_poll(2'd2, 16'h0000, 8'd0, 8'd0, 1'b1, 1'b0));
		send_poll(pad_poll(2'd2, pbr_pkg::BTN_Y | pbr_pkg::BTN_L, 8'd200, 8'd3, 1'b0, 1'b1));
		settle_polls();
	endtask

	task automatic random_phase(input logic [7:0] dz, input logic [7:0] hold,
			input int budget, input bit gaps, input int stall);
		int          sent, pick, len, k;
		logic [1:0]  p;
		logic [15:0] face, shoulder, extra, b;
		logic [63:0] rnd;
		settle_polls();
		tx_gaps = gaps;
		stall_pct = stall;
		write_reg(pbr_pkg::CFG_DEADZONE, dz);
		write_reg(pbr_pkg::CFG_HOLD_POLLS, hold);
		settings_used++;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			p = 2'($urandom_range(0, 3));
			if (pick < 8) begin
				send_poll(pad_poll(p, 16'($urandom), 8'($urandom), 8'($urandom), 1'b1,
					1'($urandom)));
				sent++;
			end else if (pick < 22) begin
				rnd = {$urandom, $urandom};
				send_poll(pbr_pkg::item_t'(rnd[35:0]));
				sent++;
			end else if (pick < 60) begin
				// a hold sequence: one short, exact or one over the needed count
				face = $urandom_range(0, 1) ? pbr_pkg::BTN_X : pbr_pkg::BTN_Y;
				case ($urandom_range(0, 2))
					0: shoulder = pbr_pkg::BTN_L;
					1: shoulder = pbr_pkg::BTN_R;
					default: shoulder = pbr_pkg::BTN_Z;
				endcase
				if ($urandom_range(0, 1)) begin
					send_poll(pad_poll(p, 16'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0));
					sent++;
				end
				len = (hold == 8'd0) ? 1 : int'(hold);
				len = len + $urandom_range(0, 2) - 1;
				if (len < 1)
					len = 1;
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_poll(pad_poll(p ^ 2'($urandom_range(1, 3)), 16'($urandom),
							8'($urandom), 8'($urandom), 1'b0, 1'($urandom)));
						sent++;
					end
					extra = 16'($urandom) & ~(pbr_pkg::FACE_PAIR | pbr_pkg::SHOULDER_SET);
					send_poll(pad_poll(p, extra | face | shoulder, 8'($urandom), 8'($urandom),
						1'b0, 1'b1));
					sent++;
				end
			end else begin
				// normal play with triggers around the deadzone
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					b = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom);
					send_poll(pad_poll(p, b, level_near(dz), level_near(dz), 1'b0,
						$urandom_range(0, 4) == 0));
					sent++;
				end
			end
		end
		settle_polls();
	endtask

	task automatic test_config_sweep();
		random_phase(8'd0, 8'd1, 250, 1'b0, 0);
		random_phase(8'd255, 8'd255, 300, 1'b1, 30);
		random_phase(8'd100, 8'd4, 250, 1'b1, 50);
		random_phase(pbr_pkg::DEADZONE_RST, pbr_pkg::HOLD_POLLS_RST, 250, 1'b1, 20);
		random_phase(8'd128, 8'd2, 250, 1'b1, 70);
		random_phase(8'd255, 8'd0, 250, 1'b0, 40);
		random_phase(8'd37, 8'd7, 250, 1'b1, 0);
	endtask

	// long output hold-off while polls keep coming, then a full drain
	task automatic test_backpressure();
		int k;
		settle_polls();
		tx_gaps = 1'b0;
		stall_pct = 0;
		write_reg(pbr_pkg::CFG_HOLD_POLLS, 8'd3);
		@(posedge clk);
		rx_hold_left = 300;
		for (k = 0; k < 48; k++)
			send_poll(pad_poll(2'(k),
				pbr_pkg::BTN_X | pbr_pkg::BTN_R | 16'($urandom & 32'h0000_f30f),
				8'($urandom), 8'($urandom), k == 20, 1'b1));
		settle_polls();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < pbr_pkg::PORT_COUNT; i++) begin
			port_mask[i] = 16'd0;
			port_hold[i] = 8'd0;
		end
		dz_level = pbr_pkg::DEADZONE_RST;
		hold_need = pbr_pkg::HOLD_POLLS_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_sweep();
		test_backpressure();

		$display("%0d polls sent, %0d results checked, %0d remaps stored",
			polls_sent, results_seen, rumbles_seen);
		$display("%0d deadzone/hold settings, unplug and setup paths, long output hold-off",
			settings_used);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
